[rtl/core/wbmp_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, result codes and the run word passed from parser to serializer.
// No dependencies.
package wbmp_pkg;

	localparam int DIM_BITS = 16;
	localparam int OUT_BITS = 16;
	localparam int ACC_BITS = DIM_BITS + 1;
	localparam int CNT_BITS = 4;

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_PIXEL  = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	localparam logic [CNT_BITS-1:0] PIX_PER_BYTE = CNT_BITS'(8);

	typedef logic [DIM_BITS-1:0] dim_t;

	typedef struct packed {
		logic                emit;
		logic [1:0]          kind;
		logic [7:0]          bits;
		logic [CNT_BITS-1:0] count;
		dim_t                x;
		dim_t                y;
		dim_t                w;
		dim_t                h;
		logic                image_done;
	} run_t;

endpackage

[rtl/core/wbmp_parser.sv]
`timescale 1ns / 1ps
// Input register and header/bitmap parse state machine; emits at most one run word per byte.
// Depends on wbmp_pkg.
module wbmp_parser (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [7:0]     data_byte,
	input  logic           ser_ready,
	output wbmp_pkg::run_t run
);
	import wbmp_pkg::*;

	typedef enum logic [2:0] {
		PH_TYPE   = 3'd0,
		PH_FIX    = 3'd1,
		PH_EXT    = 3'd2,
		PH_WIDTH  = 3'd3,
		PH_HEIGHT = 3'd4,
		PH_PIXELS = 3'd5,
		PH_ERROR  = 3'd6
	} phase_t;

	localparam dim_t PIX_DIM = dim_t'(PIX_PER_BYTE);
	localparam logic [ACC_BITS-1:0] ACC_SAT = {1'b1, {DIM_BITS{1'b0}}};

	logic                valid_s1;
	logic [7:0]          byte_s1;
	phase_t              phase_q, phase_d;
	logic [ACC_BITS-1:0] acc_q, acc_d;
	dim_t                width_q, width_d;
	dim_t                height_q, height_d;
	dim_t                col_q, col_d;
	dim_t                row_q, row_d;

	logic [ACC_BITS+6:0] shifted;
	logic                sat;
	logic [ACC_BITS-1:0] gather_val;
	logic                more;
	dim_t                left;
	logic                few;
	logic                row_done;
	logic [DIM_BITS:0]   row_inc;
	logic                image_done;
	logic                emit_raw;
	logic                consume;
	run_t                run_d;

	assign shifted    = {acc_q, byte_s1[6:0]};
	assign sat        = |shifted[ACC_BITS+6:DIM_BITS];
	assign gather_val = sat ? ACC_SAT : shifted[ACC_BITS-1:0];
	assign more       = byte_s1[7];

	assign left       = width_q - col_q;
	assign few        = left < PIX_DIM;
	assign row_done   = left <= PIX_DIM;
	assign row_inc    = {1'b0, row_q} + {{DIM_BITS{1'b0}}, 1'b1};
	assign image_done = row_done && (row_inc >= {1'b0, height_q});

	always_comb begin
		phase_d  = phase_q;
		acc_d    = acc_q;
		width_d  = width_q;
		height_d = height_q;
		col_d    = col_q;
		row_d    = row_q;
		run_d    = '0;
		run_d.count = CNT_BITS'(1);
		unique case (phase_q)
			PH_TYPE: begin
				acc_d = gather_val;
				if (!more) begin
					if (gather_val != '0) begin
						phase_d    = PH_ERROR;
						acc_d      = '0;
						run_d.emit = 1'b1;
						run_d.kind = KIND_ERROR;
					end else begin
						phase_d = PH_FIX;
					end
				end
			end
			PH_FIX: begin
				acc_d   = '0;
				phase_d = more ? PH_EXT : PH_WIDTH;
			end
			PH_EXT: begin
				acc_d = gather_val;
				if (!more) begin
					acc_d   = '0;
					phase_d = PH_WIDTH;
				end
			end
			PH_WIDTH: begin
				acc_d = gather_val;
				if (!more) begin
					acc_d = '0;
					if (gather_val[DIM_BITS]) begin
						phase_d    = PH_ERROR;
						run_d.emit = 1'b1;
						run_d.kind = KIND_ERROR;
					end else begin
						width_d = gather_val[DIM_BITS-1:0];
						phase_d = PH_HEIGHT;
					end
				end
			end
			PH_HEIGHT: begin
				acc_d = gather_val;
				if (!more) begin
					acc_d = '0;
					if (gather_val[DIM_BITS]) begin
						phase_d    = PH_ERROR;
						run_d.emit = 1'b1;
						run_d.kind = KIND_ERROR;
					end else begin
						height_d   = gather_val[DIM_BITS-1:0];
						col_d      = '0;
						row_d      = '0;
						run_d.emit = 1'b1;
						run_d.kind = KIND_HEADER;
						run_d.w    = width_q;
						run_d.h    = gather_val[DIM_BITS-1:0];
						if (width_q == '0 || gather_val[DIM_BITS-1:0] == '0) begin
							phase_d          = PH_TYPE;
							run_d.image_done = 1'b1;
						end else begin
							phase_d = PH_PIXELS;
						end
					end
				end
			end
			PH_PIXELS: begin
				run_d.emit       = 1'b1;
				run_d.kind       = KIND_PIXEL;
				run_d.bits       = byte_s1;
				run_d.count      = few ? left[CNT_BITS-1:0] : PIX_PER_BYTE;
				run_d.x          = col_q;
				run_d.y          = row_q;
				run_d.w          = width_q;
				run_d.h          = height_q;
				run_d.image_done = image_done;
				if (row_done) begin
					col_d = '0;
					row_d = row_inc[DIM_BITS-1:0];
					if (image_done) begin
						row_d   = '0;
						phase_d = PH_TYPE;
					end
				end else begin
					col_d = col_q + PIX_DIM;
				end
			end
			default: begin
			end
		endcase
	end

	assign emit_raw = run_d.emit;
	assign consume  = valid_s1 && (ser_ready || !emit_raw);
	assign in_stall = valid_s1 && !consume;

	always_comb begin
		run      = run_d;
		run.emit = valid_s1 && emit_raw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= PH_TYPE;
			acc_q    <= '0;
			width_q  <= '0;
			height_q <= '0;
			col_q    <= '0;
			row_q    <= '0;
		end else begin
			if (!valid_s1 || consume) begin
				valid_s1 <= in_valid;
			end
			if (consume) begin
				phase_q  <= phase_d;
				acc_q    <= acc_d;
				width_q  <= width_d;
				height_q <= height_d;
				col_q    <= col_d;
				row_q    <= row_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((!valid_s1 || consume) && in_valid) begin
			byte_s1 <= data_byte;
		end
	end

`ifndef SYNTHESIS
	a_error_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_ERROR) |-> !run.emit)
		else $error("run emitted in error hold");
	a_pixel_dims: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PIXELS) |-> (width_q != '0 && height_q != '0 && col_q < width_q
			&& row_q < height_q))
		else $error("pixel phase with inconsistent counters");
	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && !ser_ready))
		else $error("input stalled with no blocked word");
`endif

endmodule

[rtl/core/wbmp_serializer.sv]
`timescale 1ns / 1ps
// Result register: unpacks one run word into one result word per cycle while out_stall is low, MSB first.
// Depends on wbmp_pkg.
module wbmp_serializer (
	input  logic           clk,
	input  logic           arst_n,
	input  wbmp_pkg::run_t run,
	output logic           ser_ready,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [1:0]     result_kind,
	output logic           pixel_value,
	output logic [15:0]    pixel_x,
	output logic [15:0]    pixel_y,
	output logic [15:0]    image_width,
	output logic [15:0]    image_height,
	output logic           end_of_image,
	output logic           last_of_run
);
	import wbmp_pkg::*;

	logic                valid_q;
	logic [1:0]          kind_q;
	logic [7:0]          bits_q;
	logic [CNT_BITS-1:0] remain_q;
	dim_t                x_q;
	dim_t                y_q;
	dim_t                w_q;
	dim_t                h_q;
	logic                done_q;
	logic                take;
	logic                last;

	assign last      = remain_q == CNT_BITS'(1);
	assign take      = valid_q && !out_stall;
	assign ser_ready = !valid_q || (take && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ser_ready) begin
			valid_q <= run.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (ser_ready && run.emit) begin
			kind_q   <= run.kind;
			bits_q   <= run.bits;
			remain_q <= run.count;
			x_q      <= run.x;
			y_q      <= run.y;
			w_q      <= run.w;
			h_q      <= run.h;
			done_q   <= run.image_done;
		end else if (take) begin
			bits_q   <= {bits_q[6:0], 1'b0};
			remain_q <= remain_q - CNT_BITS'(1);
			x_q      <= x_q + dim_t'(1);
		end
	end

	assign out_valid    = valid_q;
	assign result_kind  = kind_q;
	assign pixel_value  = bits_q[7];
	assign pixel_x      = OUT_BITS'(x_q);
	assign pixel_y      = OUT_BITS'(y_q);
	assign image_width  = OUT_BITS'(w_q);
	assign image_height = OUT_BITS'(h_q);
	assign end_of_image = last && done_q;
	assign last_of_run  = last;

`ifndef SYNTHESIS
	a_remain_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (remain_q != '0 && remain_q <= PIX_PER_BYTE))
		else $error("result count out of range");
	a_single_non_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && kind_q != KIND_PIXEL) |-> last)
		else $error("header or error run longer than one word");
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !last) |=> (valid_q && kind_q == KIND_PIXEL))
		else $error("pixel run cut short");
`endif

endmodule

[rtl/core/wbmp_type0_decoder.sv]
`timescale 1ns / 1ps
// Top level of the WBMP type-0 decoder: parser followed by result serializer.
// Depends on wbmp_pkg, wbmp_parser, wbmp_serializer.
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------------
//  input   | in_valid / in_stall  | data_byte
//  output  | out_valid / out_stall| result_kind pixel_value pixel_x pixel_y
//          |                      | image_width image_height end_of_image last_of_run
//
// A header byte with no result gives no word; a header or error result is one word.
// A bitmap byte gives one word per pixel, 1 to 8, sent by the serializer at one word per cycle
// while out_stall is low; the byte passes the input register, then the result register, to the outputs.
// Reset clears the parse state at once; no clearing pass.
// One byte waits in the input register while a run drains, so input stalls only when
// both the input register and the serializer are full.
module wbmp_type0_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  result_kind,
	output logic        pixel_value,
	output logic [15:0] pixel_x,
	output logic [15:0] pixel_y,
	output logic [15:0] image_width,
	output logic [15:0] image_height,
	output logic        end_of_image,
	output logic        last_of_run
);
	import wbmp_pkg::*;

	run_t run;
	logic ser_ready;

	wbmp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.ser_ready (ser_ready),
		.run       (run)
	);

	wbmp_serializer u_serializer (
		.clk          (clk),
		.arst_n       (arst_n),
		.run          (run),
		.ser_ready    (ser_ready),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_kind  (result_kind),
		.pixel_value  (pixel_value),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.image_width  (image_width),
		.image_height (image_height),
		.end_of_image (end_of_image),
		.last_of_run  (last_of_run)
	);

endmodule

[bench/wbmp_type0_decoder_checker.sv]
`timescale 1ns / 1ps
// Watches both channels of the WBMP type-0 decoder, predicts every result word from the
// accepted file bytes and compares the words that leave, field by field.
// Depends on wbmp_pkg.
module wbmp_type0_decoder_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  result_kind,
	input  logic        pixel_value,
	input  logic [15:0] pixel_x,
	input  logic [15:0] pixel_y,
	input  logic [15:0] image_width,
	input  logic [15:0] image_height,
	input  logic        end_of_image,
	input  logic        last_of_run,
	output int          failures,
	output int          pending
);
	import wbmp_pkg::*;

	localparam logic [31:0] DIM_MAX = (32'd1 << DIM_BITS) - 32'd1;

	typedef enum logic [2:0] {
		PH_TYPE, PH_FIX, PH_EXT, PH_WIDTH, PH_HEIGHT, PH_PIXELS, PH_HALT
	} phase_e;

	typedef struct packed {
		logic [1:0]  kind;
		logic        pix;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] w;
		logic [15:0] h;
		logic        eoi;
		logic        last;
	} word_t;

	phase_e              phase;
	logic [ACC_BITS-1:0] acc;
	dim_t                wid;
	dim_t                hgt;
	dim_t                col;
	dim_t                row;
	word_t               due_words[$];
	word_t               oldest;

	function automatic void push_word(logic [1:0] kind, logic pix, dim_t x, dim_t y,
			dim_t w, dim_t h, logic eoi, logic last);
		word_t item;
		item = '{kind, pix, 16'(x), 16'(y), 16'(w), 16'(h), eoi, last};
		due_words.push_back(item);
	endfunction

	// fold one 7-bit group into the accumulator; report whether the number is complete
	function automatic bit take_group(logic [7:0] b);
		logic [31:0] v;
		v = 32'(acc) * 32'd128 + 32'(b[6:0]);
		if (v > DIM_MAX)
			v = DIM_MAX + 32'd1;
		acc = v[ACC_BITS-1:0];
		return !b[7];
	endfunction

	function automatic void halt_on_error();
		phase = PH_HALT;
		acc = '0;
		push_word(KIND_ERROR, 1'b0, '0, '0, '0, '0, 1'b0, 1'b1);
	endfunction

	function automatic void decode_byte(logic [7:0] b);
		int  left;
		int  n;
		bit  row_done;
		bit  image_done;
		case (phase)
			PH_TYPE: begin
				if (take_group(b)) begin
					if (acc != '0)
						halt_on_error();
					else
						phase = PH_FIX;
				end
			end
			PH_FIX: begin
				acc = '0;
				phase = b[7] ? PH_EXT : PH_WIDTH;
			end
			PH_EXT: begin
				if (take_group(b)) begin
					acc = '0;
					phase = PH_WIDTH;
				end
			end
			PH_WIDTH: begin
				if (take_group(b)) begin
					if (32'(acc) > DIM_MAX) begin
						halt_on_error();
					end else begin
						wid = dim_t'(acc);
						acc = '0;
						phase = PH_HEIGHT;
					end
				end
			end
			PH_HEIGHT: begin
				if (take_group(b)) begin
					if (32'(acc) > DIM_MAX) begin
						halt_on_error();
					end else begin
						hgt = dim_t'(acc);
						acc = '0;
						col = '0;
						row = '0;
						if (wid == '0 || hgt == '0) begin
							phase = PH_TYPE;
							push_word(KIND_HEADER, 1'b0, '0, '0, wid, hgt, 1'b1, 1'b1);
						end else begin
							phase = PH_PIXELS;
							push_word(KIND_HEADER, 1'b0, '0, '0, wid, hgt, 1'b0, 1'b1);
						end
					end
				end
			end
			PH_PIXELS: begin
				left = int'(wid) - int'(col);
				n = (left < 8) ? left : 8;
				row_done = (left <= 8);
				image_done = row_done && (int'(row) + 1 >= int'(hgt));
				for (int i = 0; i < n; i++)
					push_word(KIND_PIXEL, b[7 - i], dim_t'(int'(col) + i), row, wid, hgt,
						(i == n - 1) && image_done, i == n - 1);
				if (row_done) begin
					col = '0;
					row = row + 1'b1;
					if (image_done) begin
						row = '0;
						phase = PH_TYPE;
					end
				end else begin
					col = col + dim_t'(8);
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void compare_field(string label, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, label, want, got);
			failures = failures + 1;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase = PH_TYPE;
			acc = '0;
			wid = '0;
			hgt = '0;
			col = '0;
			row = '0;
			due_words.delete();
			failures = 0;
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (due_words.size() == 0) begin
					$display("%0t: word of kind %0d with none expected, got x %0d y %0d",
						$time, result_kind, pixel_x, pixel_y);
					failures = failures + 1;
				end else begin
					oldest = due_words.pop_front();
					compare_field("result_kind", oldest.kind, result_kind);
					compare_field("pixel_value", oldest.pix, pixel_value);
					compare_field("pixel_x", oldest.x, pixel_x);
					compare_field("pixel_y", oldest.y, pixel_y);
					compare_field("image_width", oldest.w, image_width);
					compare_field("image_height", oldest.h, image_height);
					compare_field("end_of_image", oldest.eoi, end_of_image);
					compare_field("last_of_run", oldest.last, last_of_run);
				end
			end
			if (in_valid && !in_stall)
				decode_byte(data_byte);
			pending <= due_words.size();
		end
	end

endmodule

[bench/wbmp_type0_decoder_test.sv]
`timescale 1ns / 1ps
// Top of the WBMP type-0 decoder bench: clock, reset, file byte stimulus and output stalls.
// Depends on wbmp_type0_decoder and wbmp_type0_decoder_checker.
module wbmp_type0_decoder_test;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  result_kind;
	logic        pixel_value;
	logic [15:0] pixel_x;
	logic [15:0] pixel_y;
	logic [15:0] image_width;
	logic [15:0] image_height;
	logic        end_of_image;
	logic        last_of_run;
	int          failures;
	int          pending;

	bit          calm = 1'b0;
	bit          idle_on = 1'b1;
	int          sent = 0;
	int          hold_left = 0;

	logic [7:0]  opening [28] = '{
		8'h00, 8'h00, 8'h08, 8'h01, 8'hA5,
		8'h80, 8'h00, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h83, 8'hFF, 8'h7F, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h83, 8'hFF, 8'h7F,
		8'h00, 8'h7F, 8'h03, 8'h02, 8'hFF, 8'h00
	};

	wbmp_type0_decoder u_dut (.*);

	wbmp_type0_decoder_checker u_check (.*);

	always #4 clk = ~clk;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
		end else if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!calm && idle_on && $urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			hold_left <= $urandom_range(0, 8);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// hold the byte until the decoder takes it
	task automatic send_byte(input logic [7:0] b);
		if (!calm && idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
	endtask

	task automatic send_number(input int unsigned value, input bit padded);
		int groups;
		groups = 1;
		while (groups < 5 && (value >> (7 * groups)) != 0)
			groups++;
		if (padded)
			send_byte(8'h80);
		for (int i = groups - 1; i >= 0; i--)
			send_byte({i != 0, 7'(value >> (7 * i))});
	endtask

	task automatic send_huge(input int runs);
		repeat (runs) send_byte(8'hFF);
		send_byte(8'h7F);
	endtask

	task automatic send_image(input int unsigned w, input int unsigned h);
		logic [7:0]  fix;
		int unsigned body;
		fix = 8'($urandom);
		send_number(0, $urandom_range(0, 4) == 0);
		send_byte(fix);
		if (fix[7]) begin
			if ($urandom_range(0, 3) == 0)
				send_huge($urandom_range(2, 4));
			else
				send_number($urandom_range(0, 20000), $urandom_range(0, 4) == 0);
		end
		send_number(w, $urandom_range(0, 4) == 0);
		send_number(h, $urandom_range(0, 4) == 0);
		body = ((w + 7) / 8) * h;
		repeat (body) send_byte(8'($urandom));
	endtask

	// end on a broken file; the decoder then swallows bytes silently
	task automatic send_broken_file();
		case ($urandom_range(0, 2))
			0: begin
				if ($urandom_range(0, 1))
					send_number($urandom_range(1, 70000), $urandom_range(0, 1));
				else
					send_huge($urandom_range(1, 3));
			end
			1: begin
				send_number(0, 1'b0);
				send_byte(8'h00);
				if ($urandom_range(0, 1))
					send_number(65536, 1'b0);
				else
					send_huge($urandom_range(2, 4));
			end
			default: begin
				send_number(0, 1'b0);
				send_byte(8'h00);
				send_number($urandom_range(1, 65535), 1'b0);
				if ($urandom_range(0, 1))
					send_number(65536, 1'b0);
				else
					send_huge($urandom_range(2, 4));
			end
		endcase
		repeat (3) send_byte(8'($urandom));
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = 8'h00;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (opening[i])
			send_byte(opening[i]);
		while (sent < 155) begin
			if (sent >= 125)
				calm <= 1'b1;
			idle_on <= ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 9))
				0: begin
					if ($urandom_range(0, 1))
						send_image(0, $urandom_range(0, 65535));
					else
						send_image($urandom_range(0, 65535), 0);
				end
				1: send_image($urandom_range(25, 70), 1);
				default: send_image($urandom_range(1, 24), $urandom_range(1, 3));
			endcase
		end
		send_broken_file();
		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (failures == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

endmodule

[files.f]
rtl/core/wbmp_pkg.sv
rtl/core/wbmp_parser.sv
rtl/core/wbmp_serializer.sv
rtl/core/wbmp_type0_decoder.sv
bench/wbmp_type0_decoder_checker.sv
bench/wbmp_type0_decoder_test.sv
